### rtl/assert_macros.svh
// assertion macros used by the sampler top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, not gated by reset
`define ASSERT_NEXT(label, clk, pre, post, msg) \
    label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

### rtl/hhs_pkg.sv
// shared types, constants and step functions of the hemisphere sampler
// no dependencies
`timescale 1ns / 1ps

package hhs_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int INDEX_BITS = 16;
    localparam int DIV_STEPS  = FRAC_BITS;
    localparam int PREP_STAGE = DIV_STEPS;
    localparam int SQRT_STEPS = FRAC_BITS + 1;
    localparam int SQRT_END   = PREP_STAGE + 1 + SQRT_STEPS;
    localparam logic [14:0] ONE = 15'(1 << FRAC_BITS);
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef enum logic {
        REG_SAMPLE_COUNT = 1'b0,
        REG_COSINE_MODE  = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic                valid;
        logic                clamped;
        logic                mode;
        logic [16:0]         n;
        logic [17:0]         rem;
        logic [13:0]         quo;
        logic [14:0]         cos_direct;
        logic [29:0]         rad_c;
        logic [29:0]         rad_s;
        logic [19:0]         rem_c;
        logic [19:0]         rem_s;
        logic [14:0]         root_c;
        logic [14:0]         root_s;
        logic [1:0]          quad;
        logic signed [33:0]  cx;
        logic signed [33:0]  cy;
        logic signed [32:0]  cz;
    } t_pipe;

    typedef struct packed {
        logic [29:0] rad;
        logic [19:0] rem;
        logic [14:0] root;
    } t_sqrt;

    function automatic logic [31:0] bit_rev(input logic [31:0] b);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[31 - i] = b[i];
        end
        return r;
    endfunction

    // one digit of the restoring square root, two radicand bits in
    function automatic t_sqrt sqrt_step(input t_sqrt s);
        t_sqrt       o;
        logic [19:0] sh;
        logic [19:0] trial;
        sh    = {s.rem[17:0], s.rad[29:28]};
        trial = {3'b000, s.root[14:0], 2'b01};
        o.rad = {s.rad[27:0], 2'b00};
        if (sh >= trial) begin
            o.rem  = sh - trial;
            o.root = {s.root[13:0], 1'b1};
        end else begin
            o.rem  = sh;
            o.root = {s.root[13:0], 1'b0};
        end
        return o;
    endfunction

endpackage

### rtl/hammersley_hemisphere_sampler.sv
// Hammersley hemisphere sampler: one direction per sample index, fully pipelined.
// An index is taken every cycle unless the output stalls; each result passes through
// max(30, CORDIC_STEPS) + 2 register stages: the 14 restoring divider stages, one
// root prep stage and 15 square root digit stages running beside the cordic rotation
// stages, then a multiply stage and a round/saturate output register. A stall on
// the output freezes the whole pipe. Uses hhs_pkg and hhs_stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hammersley_hemisphere_sampler #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [16:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // dir_x, dir_y, dir_z, zero pad
    output logic        m_axis_tuser    // index_clamped
);

    localparam int DEPTH = (CORDIC_STEPS > hhs_pkg::SQRT_END) ? CORDIC_STEPS
                                                              : hhs_pkg::SQRT_END;

    logic [16:0] r_count;
    logic        r_mode;
    logic        en;

    hhs_pkg::t_pipe pipe [DEPTH + 1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 17'd256;
            r_mode  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (hhs_pkg::t_reg_index'(i_cfg_addr))
                hhs_pkg::REG_SAMPLE_COUNT: r_count <= i_cfg_wdata;
                hhs_pkg::REG_COSINE_MODE:  r_mode  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input stage: clamp test, radical inverse and quadrant split
    always_comb begin
        logic [31:0] v;
        logic [31:0] vq;
        logic [31:0] r;
        logic        clamped;
        v       = hhs_pkg::bit_rev({16'b0, s_axis_tdata});
        vq      = v + 32'h2000_0000;
        r       = v - {vq[31:30], 30'b0};
        clamped = {1'b0, s_axis_tdata} >= r_count;
        pipe[0]            = '0;
        pipe[0].valid      = s_axis_tvalid;
        pipe[0].clamped    = clamped;
        pipe[0].mode       = r_mode;
        pipe[0].n          = r_count;
        pipe[0].rem        = clamped ? 18'd0 : {2'b00, s_axis_tdata};
        pipe[0].quad       = vq[31:30];
        pipe[0].cx         = hhs_pkg::GAIN_Q30;
        pipe[0].cy         = '0;
        pipe[0].cz         = signed'({r[31], r});
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_stage
        hhs_stage #(
            .STAGE        (k),
            .CORDIC_STEPS (CORDIC_STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (pipe[k]),
            .o_q     (pipe[k + 1])
        );
    end

    // multiply stage
    logic               r_mul_valid;
    logic               r_mul_clamped;
    logic [14:0]        r_mul_cos;
    logic signed [49:0] r_px;
    logic signed [49:0] r_py;
    logic signed [33:0] c_sel;
    logic signed [33:0] s_sel;
    logic [14:0]        sin_t;
    logic [14:0]        cos_t;
    hhs_pkg::t_pipe     last;

    assign last  = pipe[DEPTH];
    assign sin_t = last.root_s;
    assign cos_t = last.mode ? last.root_c : last.cos_direct;

    always_comb begin
        unique case (last.quad)
            2'd0: begin c_sel = last.cx;  s_sel = last.cy;  end
            2'd1: begin c_sel = -last.cy; s_sel = last.cx;  end
            2'd2: begin c_sel = -last.cx; s_sel = -last.cy; end
            default: begin c_sel = last.cy; s_sel = -last.cx; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (en) begin
            r_mul_valid <= last.valid;
        end
        if (en) begin
            r_mul_clamped <= last.clamped;
            r_mul_cos     <= cos_t;
            r_px          <= c_sel * signed'({1'b0, sin_t});
            r_py          <= s_sel * signed'({1'b0, sin_t});
        end
    end

    // round half up, then saturate to plus or minus one
    function automatic logic [15:0] round_sat(input logic signed [49:0] p);
        logic signed [49:0] t;
        logic signed [19:0] r;
        t = (p + 50'sd536870912) >>> 30;
        r = t[19:0];
        if (t > 50'sd16384) begin
            r = 20'sd16384;
        end else if (t < -50'sd16384) begin
            r = -20'sd16384;
        end
        return r[15:0];
    endfunction

    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic        r_out_clamped;

    assign en = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_mul_valid;
        end
        if (en) begin
            r_out_data    <= {1'b0, r_mul_cos, round_sat(r_py), round_sat(r_px)};
            r_out_clamped <= r_mul_clamped;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_clamped;

    `ASSERT_IMPL(a_clamp_z, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[46:32] == 15'd0, "clamped transfer with nonzero z")
    `ASSERT_IMPL(a_z_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[46:32] <= 15'd16384 && !m_axis_tdata[47], "z out of range")
    `ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")

endmodule

### rtl/hhs_stage.sv
// one register stage of the sampler pipeline: divider bit, root prep,
// square root digits and cordic rotation, chosen by stage number; uses hhs_pkg
`timescale 1ns / 1ps

module hhs_stage #(
    parameter int STAGE        = 0,
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  hhs_pkg::t_pipe i_d,
    output hhs_pkg::t_pipe o_q
);

    hhs_pkg::t_pipe r_q;
    hhs_pkg::t_pipe n_q;

    always_comb begin
        logic [17:0]        rem2;
        logic [14:0]        u;
        logic [14:0]        onem;
        logic [29:0]        sq;
        hhs_pkg::t_sqrt     sc;
        hhs_pkg::t_sqrt     ss;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [32:0] at;
        n_q  = i_d;
        rem2 = {i_d.rem[16:0], 1'b0};
        u    = i_d.clamped ? hhs_pkg::ONE : {1'b0, i_d.quo};
        onem = hhs_pkg::ONE - u;
        sq   = 30'(onem * onem);
        sc   = '{rad: i_d.rad_c, rem: i_d.rem_c, root: i_d.root_c};
        ss   = '{rad: i_d.rad_s, rem: i_d.rem_s, root: i_d.root_s};
        dx   = i_d.cy >>> (STAGE % 32);
        dy   = i_d.cx >>> (STAGE % 32);
        at   = signed'({1'b0, hhs_pkg::ATAN_TURNS[STAGE % 32]});
        if (STAGE < hhs_pkg::DIV_STEPS) begin
            if (rem2 >= {1'b0, i_d.n}) begin
                n_q.rem = rem2 - {1'b0, i_d.n};
                n_q.quo = {i_d.quo[12:0], 1'b1};
            end else begin
                n_q.rem = rem2;
                n_q.quo = {i_d.quo[12:0], 1'b0};
            end
        end else if (STAGE == hhs_pkg::PREP_STAGE) begin
            n_q.cos_direct = onem;
            n_q.rem_c  = '0;
            n_q.rem_s  = '0;
            n_q.root_c = '0;
            n_q.root_s = '0;
            if (i_d.mode) begin
                n_q.rad_c = {1'b0, onem, 14'b0};
                n_q.rad_s = {1'b0, u, 14'b0};
            end else begin
                n_q.rad_c = '0;
                n_q.rad_s = 30'(1 << 28) - sq;
            end
        end else if (STAGE < hhs_pkg::SQRT_END) begin
            sc = hhs_pkg::sqrt_step(sc);
            ss = hhs_pkg::sqrt_step(ss);
            n_q.rad_c  = sc.rad;
            n_q.rem_c  = sc.rem;
            n_q.root_c = sc.root;
            n_q.rad_s  = ss.rad;
            n_q.rem_s  = ss.rem;
            n_q.root_s = ss.root;
        end
        if (STAGE < CORDIC_STEPS) begin
            if (!i_d.cz[32]) begin
                n_q.cx = i_d.cx - dx;
                n_q.cy = i_d.cy + dy;
                n_q.cz = i_d.cz - at;
            end else begin
                n_q.cx = i_d.cx + dx;
                n_q.cy = i_d.cy - dy;
                n_q.cz = i_d.cz + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q.valid <= n_q.valid;
        end
        if (i_en) begin
            r_q.clamped    <= n_q.clamped;
            r_q.mode       <= n_q.mode;
            r_q.n          <= n_q.n;
            r_q.rem        <= n_q.rem;
            r_q.quo        <= n_q.quo;
            r_q.cos_direct <= n_q.cos_direct;
            r_q.rad_c      <= n_q.rad_c;
            r_q.rad_s      <= n_q.rad_s;
            r_q.rem_c      <= n_q.rem_c;
            r_q.rem_s      <= n_q.rem_s;
            r_q.root_c     <= n_q.root_c;
            r_q.root_s     <= n_q.root_s;
            r_q.quad       <= n_q.quad;
            r_q.cx         <= n_q.cx;
            r_q.cy         <= n_q.cy;
            r_q.cz         <= n_q.cz;
        end
    end

    assign o_q = r_q;

endmodule

### sim/tb_top.sv
// testbench for the hemisphere sampler: queue-fed stream driver, monitor and predictor
// depends on hhs_pkg and hammersley_hemisphere_sampler
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [14:0]        dz;
        logic               clamp;
    } t_dir;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;   // dir_x, dir_y, dir_z, zero pad
    logic        m_axis_tuser;   // index_clamped

    hammersley_hemisphere_sampler DUT (.*);

    always #6 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [16:0] count_q = 17'd256;
    logic        cos_mode_q = 1'b1;

    logic [15:0] index_queue [$];
    t_dir        dir_queue [$];
    int          errors = 0;
    int          checked = 0;
    int          cycles = 0;
    bit          calm = 0;      // no idling in the last part
    bit          gate = 0;      // sender on while set
    bit          hold_rx = 0;   // long receiver hold-off request

    function automatic longint fl_shift(longint a, int k);
        if (a >= 0) return a >>> k;
        return -((-a - 1) >>> k) - 1;
    endfunction

    function automatic longint isqrt(longint x);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= x) r++;
        return r;
    endfunction

    function automatic longint scale_sat(longint trig, longint mag);
        longint r;
        r = fl_shift(trig * mag + (64'sd1 <<< 29), 30);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    function automatic t_dir predict_dir(logic [15:0] idx);
        t_dir        d;
        longint      u, ct, st, x, y, z, c, s, dx, dy;
        logic [31:0] v, r, q;
        d.clamp = ({1'b0, idx} >= count_q);
        u = d.clamp ? 16384 : (longint'(idx) * 16384) / count_q;
        if (cos_mode_q) begin
            ct = isqrt((16384 - u) * 16384);
            st = isqrt(u * 16384);
        end else begin
            ct = 16384 - u;
            st = isqrt(16384 * 16384 - ct * ct);
        end
        for (int i = 0; i < 32; i++) v[31 - i] = (i < 16) ? idx[i] : 1'b0;
        q = ((v + 32'h2000_0000) >> 30) & 3;
        r = v - (q << 30);
        z = longint'($signed(r));
        x = 652032874;
        y = 0;
        for (int k = 0; k < 16; k++) begin
            dx = fl_shift(y, k);
            dy = fl_shift(x, k);
            if (z >= 0) begin
                x -= dx; y += dy; z -= hhs_pkg::ATAN_TURNS[k];
            end else begin
                x += dx; y -= dy; z += hhs_pkg::ATAN_TURNS[k];
            end
        end
        case (q)
            0: begin c = x; s = y; end
            1: begin c = -y; s = x; end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        d.dx = 16'(scale_sat(c, st));
        d.dy = 16'(scale_sat(s, st));
        d.dz = 15'(ct);
        return d;
    endfunction

    // driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            dir_queue.push_back(predict_dir(s_axis_tdata));
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (gate && index_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= index_queue.pop_front();
                if (!calm && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 18);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor with random stalls and one long hold-off
    int rx_gap = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            t_dir e;
            t_dir a;
            a.dx = m_axis_tdata[15:0];
            a.dy = m_axis_tdata[31:16];
            a.dz = m_axis_tdata[46:32];
            a.clamp = m_axis_tuser;
            if (dir_queue.size() == 0) begin
                $display("%0t: unexpected transfer %h/%b", $time, m_axis_tdata, m_axis_tuser);
                errors <= errors + 1;
            end else begin
                e = dir_queue.pop_front();
                checked <= checked + 1;
                if (e.dx !== a.dx || e.dy !== a.dy || e.dz !== a.dz || e.clamp !== a.clamp
                        || m_axis_tdata[47] !== 1'b0) begin
                    $display("%0t: mismatch exp x=%0d y=%0d z=%0d c=%b act x=%0d y=%0d z=%0d c=%b",
                        $time, e.dx, e.dy, e.dz, e.clamp, a.dx, a.dy, a.dz, a.clamp);
                    errors <= errors + 1;
                end
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_rx) begin
            rx_gap <= 200;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(1, 18) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic drain();
        gate = 1;
        while (index_queue.size() > 0 || s_axis_tvalid || dir_queue.size() > 0)
            @(negedge i_clk);
        gate = 0;
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(hhs_pkg::t_reg_index a, logic [16:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (a == hhs_pkg::REG_SAMPLE_COUNT) count_q = val;
        else cos_mode_q = val[0];
    endtask

    initial begin
        int plan_count [6] = '{256, 1, 65536, 0, 100000, 1000};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: reset setting, field extremes and clamp
        foreach (plan_count[i]) if (i == 0) begin
            index_queue = '{16'd0, 16'd1, 16'd255, 16'd256, 16'hFFFF, 16'h8000,
                            16'h4000, 16'hC000, 16'h5555, 16'hAAAA, 16'd128};
        end
        drain();
        write_reg(hhs_pkg::REG_COSINE_MODE, 17'd0);
        index_queue = '{16'd0, 16'd64, 16'd255, 16'd300, 16'hFFFF, 16'd1, 16'd192};
        drain();
        // random phases over several settings, long hold-off in the first
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(hhs_pkg::REG_SAMPLE_COUNT, 17'(plan_count[ph]));
            write_reg(hhs_pkg::REG_COSINE_MODE, {16'b0, ph[0]});
            if (ph == 5) calm = 1;
            for (int n = 0; n < 155; n++) begin
                logic [15:0] idx;
                if (count_q > 1 && $urandom_range(0, 3) != 0)
                    idx = 16'($urandom_range(0, (count_q > 65536 ? 65536 : count_q) - 1));
                else idx = 16'($urandom);
                index_queue.push_back(idx);
            end
            if (ph == 0) begin
                gate = 1;
                hold_rx = 1;
                repeat (2) @(posedge i_clk);
                hold_rx = 0;
            end
            drain();
        end
        $display("covered %0d directions over six count/mode settings incl. zero and max",
                 checked);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/hhs_pkg.sv
rtl/hhs_stage.sv
rtl/hammersley_hemisphere_sampler.sv
sim/tb_top.sv
